// ===== hw/rtl/rgbc_pkg.sv =====
`timescale 1ns / 1ps

package rgbc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SHARE_W      = 10;
    localparam int TOTAL_W      = SAMPLE_WIDTH + 2;
    localparam int NUM_W        = SAMPLE_WIDTH + SHARE_W;
    localparam int TRIAL_W      = TOTAL_W + SHARE_W;
    localparam int BIT_W        = $clog2(SHARE_W);
    localparam int CLEAR_W      = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_CHAN     = 3;
    localparam int CHAN_W       = $clog2(NUM_CHAN);

    localparam logic [SHARE_W-1:0] PER_MILLE    = SHARE_W'(1000);
    localparam logic [SHARE_W-1:0] GB_MARGIN    = SHARE_W'(70);
    localparam logic [SHARE_W-1:0] YEL_MIN      = SHARE_W'(330);
    localparam logic [SHARE_W-1:0] YEL_BLUE_MAX = SHARE_W'(280);

    localparam int CODE_W = 3;

    typedef enum logic [CODE_W-1:0] {
        COLOR_NONE    = 3'd0,
        COLOR_RED     = 3'd1,
        COLOR_GREEN   = 3'd2,
        COLOR_BLUE    = 3'd3,
        COLOR_YELLOW  = 3'd4,
        COLOR_WHITE   = 3'd5,
        COLOR_UNKNOWN = 3'd6
    } color_code_t;

    typedef enum logic [2:0] {
        REG_MIN_CLEAR       = 3'd0,
        REG_WHITE_MIN_CLEAR = 3'd1,
        REG_WHITE_LOW       = 3'd2,
        REG_WHITE_HIGH      = 3'd3,
        REG_RED_MIN         = 3'd4,
        REG_RED_MARGIN      = 3'd5,
        REG_GREEN_MIN       = 3'd6,
        REG_BLUE_MIN        = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [CLEAR_W-1:0] min_clear;
        logic [CLEAR_W-1:0] white_min_clear;
        logic [SHARE_W-1:0] white_low;
        logic [SHARE_W-1:0] white_high;
        logic [SHARE_W-1:0] red_min;
        logic [SHARE_W-1:0] red_margin;
        logic [SHARE_W-1:0] green_min;
        logic [SHARE_W-1:0] blue_min;
    } cfg_t;

    typedef struct packed {
        logic                    none;
        logic                    bright;
        logic [SAMPLE_WIDTH-1:0] red;
        logic [SAMPLE_WIDTH-1:0] green;
        logic [SAMPLE_WIDTH-1:0] blue;
        logic [TOTAL_W-1:0]      total;
    } sample_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_RULES
    } back_state_t;

endpackage

// ===== hw/rtl/rgbc_front.sv =====
`timescale 1ns / 1ps

module rgbc_front
    import rgbc_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output sample_t     q_entry
);

    logic [SAMPLE_WIDTH-1:0] clear_s;
    logic [SAMPLE_WIDTH-1:0] red_s;
    logic [SAMPLE_WIDTH-1:0] green_s;
    logic [SAMPLE_WIDTH-1:0] blue_s;
    logic [TOTAL_W-1:0]      total;
    logic [CLEAR_W-1:0]      clear_ext;

    assign clear_s = s_tdata[SAMPLE_WIDTH-1:0];
    assign red_s   = s_tdata[16 +: SAMPLE_WIDTH];
    assign green_s = s_tdata[32 +: SAMPLE_WIDTH];
    assign blue_s  = s_tdata[48 +: SAMPLE_WIDTH];

    assign clear_ext = CLEAR_W'(clear_s);
    assign total = TOTAL_W'(red_s) + TOTAL_W'(green_s) + TOTAL_W'(blue_s);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.none   = (clear_ext < cfg.min_clear) || (total == '0);
        q_entry.bright = clear_ext > cfg.white_min_clear;
        q_entry.red    = red_s;
        q_entry.green  = green_s;
        q_entry.blue   = blue_s;
        q_entry.total  = total;
    end

endmodule

// ===== hw/rtl/rgbc_queue.sv =====
`timescale 1ns / 1ps

module rgbc_queue
    import rgbc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  sample_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output sample_t head_data
);

    sample_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rgbc_back.sv =====
`timescale 1ns / 1ps

module rgbc_back
    import rgbc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  sample_t    q_data,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    back_state_t         state_reg, state_next;
    logic [NUM_W-1:0]    num_reg [NUM_CHAN];
    logic [SHARE_W-1:0]  share_reg [NUM_CHAN];
    logic [TOTAL_W-1:0]  total_reg;
    logic                none_reg;
    logic                bright_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                out_valid_reg;
    color_code_t         out_code_reg;

    logic                load;
    logic                div_step;
    logic                emit;
    logic                out_free;
    logic                last_step;

    logic [TRIAL_W-1:0]  trial;
    logic [TRIAL_W-1:0]  num_ext;
    logic                fits;
    logic [TRIAL_W-1:0]  diff;

    logic [SHARE_W-1:0]  rs, gs, bs;
    logic                white_hit, red_hit, green_hit, blue_hit, yellow_hit;
    color_code_t         code;

    assign out_free  = !out_valid_reg || m_tready;
    assign last_step = (bit_reg == '0) && (chan_reg == CHAN_W'(NUM_CHAN - 1));

    // one quotient bit per cycle, the quotient is known to fit in SHARE_W bits
    assign trial   = TRIAL_W'(total_reg) << bit_reg;
    assign num_ext = TRIAL_W'(num_reg[chan_reg]);
    assign fits    = num_ext >= trial;
    assign diff    = num_ext - trial;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = q_data.none ? BK_RULES : BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_step) begin
                    state_next = BK_RULES;
                end
            end
            BK_RULES: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        load     = 1'b0;
        div_step = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            BK_IDLE:  load     = q_valid;
            BK_DIV:   div_step = 1'b1;
            BK_RULES: emit     = out_free;
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign q_pop = load;

    always_comb begin
        rs = share_reg[0];
        gs = share_reg[1];
        bs = share_reg[2];
        white_hit = bright_reg
            && (rs > cfg.white_low) && (rs < cfg.white_high)
            && (gs > cfg.white_low) && (gs < cfg.white_high)
            && (bs > cfg.white_low) && (bs < cfg.white_high);
        red_hit = (rs > cfg.red_min)
            && ({1'b0, rs} > ({1'b0, gs} + {1'b0, cfg.red_margin}))
            && ({1'b0, rs} > ({1'b0, bs} + {1'b0, cfg.red_margin}));
        green_hit = (gs > cfg.green_min)
            && ({1'b0, gs} > ({1'b0, rs} + {1'b0, GB_MARGIN}))
            && ({1'b0, gs} > ({1'b0, bs} + {1'b0, GB_MARGIN}));
        blue_hit = (bs > cfg.blue_min)
            && ({1'b0, bs} > ({1'b0, rs} + {1'b0, GB_MARGIN}))
            && ({1'b0, bs} > ({1'b0, gs} + {1'b0, GB_MARGIN}));
        yellow_hit = (rs > YEL_MIN) && (gs > YEL_MIN) && (bs < YEL_BLUE_MAX);
        priority if (none_reg) begin
            code = COLOR_NONE;
        end else if (white_hit) begin
            code = COLOR_WHITE;
        end else if (red_hit) begin
            code = COLOR_RED;
        end else if (green_hit) begin
            code = COLOR_GREEN;
        end else if (blue_hit) begin
            code = COLOR_BLUE;
        end else if (yellow_hit) begin
            code = COLOR_YELLOW;
        end else begin
            code = COLOR_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg[0] <= NUM_W'(q_data.red) * NUM_W'(PER_MILLE);
            num_reg[1] <= NUM_W'(q_data.green) * NUM_W'(PER_MILLE);
            num_reg[2] <= NUM_W'(q_data.blue) * NUM_W'(PER_MILLE);
            total_reg  <= q_data.total;
            none_reg   <= q_data.none;
            bright_reg <= q_data.bright;
            chan_reg   <= '0;
            bit_reg    <= BIT_W'(SHARE_W - 1);
        end else if (div_step) begin
            share_reg[chan_reg][bit_reg] <= fits;
            if (fits) begin
                num_reg[chan_reg] <= diff[NUM_W-1:0];
            end
            if (bit_reg == '0) begin
                chan_reg <= chan_reg + CHAN_W'(1);
                bit_reg  <= BIT_W'(SHARE_W - 1);
            end else begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
        if (emit) begin
            out_code_reg <= code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - CODE_W){1'b0}}, out_code_reg};

endmodule

// ===== hw/rtl/rgbc_color_classifier.sv =====
`timescale 1ns / 1ps

// Colour classifier for one clear/red/green/blue sample per input transaction.
// The front end takes a transaction whenever its four-entry queue has room,
// flags dark or zero-sum samples and forms red+green+blue; the back end scales
// each colour to parts per thousand with one shared shift-subtract divider
// (one quotient bit a cycle, ten bits a channel) and then applies the white,
// red, green, blue and yellow rules in that order. A lit sample goes through
// load, divider steps and rule check in the back end, a dark or zero-sum one
// skips the divider, and no new sample is taken until the last one leaves the
// rule check. Results wait in an output register, so the queue keeps filling
// while a result is stalled. The eight threshold registers sit on the APB port
// at byte addresses 0 to 28 and should only be written while the block is idle.

module rgbc_color_classifier
    import rgbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // clear_count [15:0], red_count [31:16], green_count [47:32], blue_count [63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // color_code [2:0], zero [7:3]
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    reg_index_t reg_idx;
    logic       cfg_write;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    sample_t    q_entry;
    sample_t    q_head;

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_clear       <= CLEAR_W'(80);
            cfg_reg.white_min_clear <= CLEAR_W'(600);
            cfg_reg.white_low       <= SHARE_W'(250);
            cfg_reg.white_high      <= SHARE_W'(400);
            cfg_reg.red_min         <= SHARE_W'(430);
            cfg_reg.red_margin      <= SHARE_W'(80);
            cfg_reg.green_min       <= SHARE_W'(400);
            cfg_reg.blue_min        <= SHARE_W'(390);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_MIN_CLEAR:       cfg_reg.min_clear       <= pwdata[CLEAR_W-1:0];
                REG_WHITE_MIN_CLEAR: cfg_reg.white_min_clear <= pwdata[CLEAR_W-1:0];
                REG_WHITE_LOW:       cfg_reg.white_low       <= pwdata[SHARE_W-1:0];
                REG_WHITE_HIGH:      cfg_reg.white_high      <= pwdata[SHARE_W-1:0];
                REG_RED_MIN:         cfg_reg.red_min         <= pwdata[SHARE_W-1:0];
                REG_RED_MARGIN:      cfg_reg.red_margin      <= pwdata[SHARE_W-1:0];
                REG_GREEN_MIN:       cfg_reg.green_min       <= pwdata[SHARE_W-1:0];
                REG_BLUE_MIN:        cfg_reg.blue_min        <= pwdata[SHARE_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_CLEAR:       prdata = 32'(cfg_reg.min_clear);
            REG_WHITE_MIN_CLEAR: prdata = 32'(cfg_reg.white_min_clear);
            REG_WHITE_LOW:       prdata = 32'(cfg_reg.white_low);
            REG_WHITE_HIGH:      prdata = 32'(cfg_reg.white_high);
            REG_RED_MIN:         prdata = 32'(cfg_reg.red_min);
            REG_RED_MARGIN:      prdata = 32'(cfg_reg.red_margin);
            REG_GREEN_MIN:       prdata = 32'(cfg_reg.green_min);
            REG_BLUE_MIN:        prdata = 32'(cfg_reg.blue_min);
            default:             prdata = '0;
        endcase
    end

    rgbc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    rgbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    rgbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
